// ----- rtl/core/data_frame_receiver_checksum_top_macros.svh -----
// assertion macros used by dfrc_checker
`ifndef DATA_FRAME_RECEIVER_CHECKSUM_TOP_MACROS_SVH
`define DATA_FRAME_RECEIVER_CHECKSUM_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define DFRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DFRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dfrc_pkg.sv -----
`default_nettype none

package dfrc_pkg;

	// input item modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// final status codes
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_MISMATCH = 3'd1;
	localparam logic [2:0] STATUS_ACK_ERR  = 3'd2;
	localparam logic [2:0] STATUS_DEVICE   = 3'd3;
	localparam logic [2:0] STATUS_TIMEOUT  = 3'd4;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_LEVEL_TWO    = 3'd0;
	localparam logic [2:0] REG_END_BLOCK    = 3'd1;
	localparam logic [2:0] REG_HEADER_LEN   = 3'd2;
	localparam logic [2:0] REG_TIMEOUT      = 3'd3;
	localparam logic [2:0] REG_NORMAL_END   = 3'd4;
	localparam logic [2:0] REG_ERROR_END    = 3'd5;

	localparam logic [7:0] LINE_FEED   = 8'h0a;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] ALPHA_SHIFT = 8'd7;
	localparam logic [5:0] IDLE_MAX    = 6'd63;
	localparam logic [8:0] POS_MAX     = 9'd511;

	typedef struct packed {
		logic       level_two;
		logic [7:0] end_block_char;
		logic [7:0] header_length;
		logic [5:0] timeout_seconds;
		logic [7:0] normal_end_code;
		logic [7:0] error_end_code;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] value;
		logic [2:0] status;
	} result_t;

	// ascii hex character to nibble, letters either case above '9'
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = (c > CHAR_NINE) ? (c - ALPHA_SHIFT) : c;
		v = v - CHAR_ZERO;
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dfrc_rx_engine.sv -----
`default_nettype none

module dfrc_rx_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [1:0]      mode,
	input  wire logic [7:0]      rx_byte,
	input  wire dfrc_pkg::cfg_t  cfg,
	output dfrc_pkg::result_t    res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ACK,
		PH_REASON,
		PH_HEADER,
		PH_DATA,
		PH_CHECK
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] sum_q, sum_d;
	logic [8:0]  pos_q, pos_d;
	logic [3:0]  digit_q [4];
	logic [2:0]  dcount_q, dcount_d;
	logic [5:0]  idle_q, idle_d;
	logic        digit_wr;
	logic [5:0]  idle_inc;
	logic [15:0] check_code;

	// check value: first pair is the low byte, second pair the high byte
	assign check_code = {digit_q[2], digit_q[3], digit_q[0], digit_q[1]};
	assign idle_inc   = (idle_q < dfrc_pkg::IDLE_MAX) ? (idle_q + 6'd1) : idle_q;

	// next state and result for the item being transferred
	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		pos_d    = pos_q;
		dcount_d = dcount_q;
		idle_d   = idle_q;
		digit_wr = 1'b0;
		res      = '0;
		case (mode)
			dfrc_pkg::MODE_START: begin
				phase_d  = PH_ACK;
				sum_d    = '0;
				pos_d    = '0;
				dcount_d = '0;
				idle_d   = '0;
			end
			dfrc_pkg::MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					idle_d = idle_inc;
					if (idle_inc >= cfg.timeout_seconds) begin
						phase_d    = PH_IDLE;
						res.valid  = 1'b1;
						res.kind   = dfrc_pkg::KIND_STATUS;
						res.status = dfrc_pkg::STATUS_TIMEOUT;
					end
				end
			end
			dfrc_pkg::MODE_BYTE: begin
				if (phase_q != PH_IDLE) begin
					idle_d = '0;
				end
				case (phase_q)
					PH_IDLE: begin
					end
					PH_ACK: begin
						if (rx_byte == cfg.error_end_code && cfg.level_two) begin
							phase_d = PH_REASON;
						end else if (rx_byte != cfg.normal_end_code) begin
							phase_d    = PH_IDLE;
							res.valid  = 1'b1;
							res.kind   = dfrc_pkg::KIND_STATUS;
							res.status = dfrc_pkg::STATUS_ACK_ERR;
						end else begin
							phase_d = cfg.level_two ? PH_HEADER : PH_DATA;
						end
					end
					PH_REASON: begin
						phase_d    = PH_IDLE;
						res.valid  = 1'b1;
						res.kind   = dfrc_pkg::KIND_STATUS;
						res.value  = rx_byte;
						res.status = dfrc_pkg::STATUS_DEVICE;
					end
					PH_HEADER: begin
						if (rx_byte == dfrc_pkg::LINE_FEED) begin
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						sum_d = sum_q + {8'd0, rx_byte};
						if (pos_q < dfrc_pkg::POS_MAX) begin
							pos_d = pos_q + 9'd1;
						end
						if (rx_byte == cfg.end_block_char) begin
							phase_d = PH_CHECK;
						end
						// bytes past the header go out
						if (pos_q >= {1'b0, cfg.header_length}) begin
							res.valid = 1'b1;
							res.kind  = dfrc_pkg::KIND_DATA;
							res.value = rx_byte;
						end
					end
					PH_CHECK: begin
						if (rx_byte == cfg.end_block_char) begin
							phase_d    = PH_IDLE;
							res.valid  = 1'b1;
							res.kind   = dfrc_pkg::KIND_STATUS;
							res.status = (dcount_q[2] && check_code == sum_q) ?
								dfrc_pkg::STATUS_OK : dfrc_pkg::STATUS_MISMATCH;
						end else if (!dcount_q[2]) begin
							digit_wr = 1'b1;
							dcount_d = dcount_q + 3'd1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
		if (!take) begin
			res.valid = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			sum_q    <= '0;
			pos_q    <= '0;
			dcount_q <= '0;
			idle_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			sum_q    <= sum_d;
			pos_q    <= pos_d;
			dcount_q <= dcount_d;
			idle_q   <= idle_d;
		end
	end

	// checksum digits, held as nibbles; only read once all four are written
	always_ff @(posedge clk) begin
		if (take && digit_wr) begin
			digit_q[dcount_q[1:0]] <= dfrc_pkg::hex_digit(rx_byte);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/data_frame_receiver_checksum_top.sv -----
`default_nettype none

// Frame receiver: takes one item per clock (start, received byte or one-second tick) and
// works it combinationally against the transfer state, placing at most one result
// (forwarded data byte or final status) in the output register. The input side stays
// ready while that register is empty or being emptied in the same cycle, so items flow
// back to back; in_ready drops only while a result waits and out_ready is low. Results
// are registered for the next cycle. There is no clearing pass after reset. Configuration
// writes are taken at once (cfg_ready is always high) and should only be made while idle.
module data_frame_receiver_checksum_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// item input
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] rx_byte,
	// result output
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [7:0]      value,
	output logic [2:0]      status,
	// configuration writes
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	dfrc_pkg::cfg_t    cfg_q;
	dfrc_pkg::result_t res;
	logic              in_xfer;
	logic              out_valid_q;
	logic              kind_q;
	logic [7:0]        value_q;
	logic [2:0]        status_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_two       <= 1'b1;
			cfg_q.end_block_char  <= 8'd26;
			cfg_q.header_length   <= 8'd0;
			cfg_q.timeout_seconds <= 6'd30;
			cfg_q.normal_end_code <= 8'd6;
			cfg_q.error_end_code  <= 8'd21;
		end else if (cfg_valid) begin
			case (cfg_index)
				dfrc_pkg::REG_LEVEL_TWO:  cfg_q.level_two       <= cfg_data[0];
				dfrc_pkg::REG_END_BLOCK:  cfg_q.end_block_char  <= cfg_data;
				dfrc_pkg::REG_HEADER_LEN: cfg_q.header_length   <= cfg_data;
				dfrc_pkg::REG_TIMEOUT:    cfg_q.timeout_seconds <= cfg_data[5:0];
				dfrc_pkg::REG_NORMAL_END: cfg_q.normal_end_code <= cfg_data;
				dfrc_pkg::REG_ERROR_END:  cfg_q.error_end_code  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dfrc_rx_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_xfer),
		.mode    (mode),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.res     (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			kind_q   <= res.kind;
			value_q  <= res.value;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ----- rtl/core/dfrc_checker.sv -----
`default_nettype none

`include "data_frame_receiver_checksum_top_macros.svh"

module dfrc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] mode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       kind,
	input wire logic [7:0] value,
	input wire logic [2:0] status
);

	// a waiting result holds until its transfer
	`DFRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value) && $stable(status), "result changed while stalled")

	// input back-pressure only from a stalled result
	`DFRC_ASSERT_IMPL(a_ready_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")

	// forwarded data carries ok status
	`DFRC_ASSERT_IMPL(a_data_status, clk, arst_n, out_valid && kind == dfrc_pkg::KIND_DATA, status == dfrc_pkg::STATUS_OK, "data byte with non-ok status")

	// only a device error carries a value with a status
	`DFRC_ASSERT(a_status_value, clk, arst_n, !(out_valid && kind == dfrc_pkg::KIND_STATUS && status != dfrc_pkg::STATUS_DEVICE && value != 8'd0), "status result with stray value")

	// a start item gives no result of its own
	`DFRC_ASSERT_NEXT(a_start_quiet, clk, arst_n, in_valid && in_ready && mode == dfrc_pkg::MODE_START && !(out_valid && !out_ready), !out_valid, "result after start item")

endmodule

bind data_frame_receiver_checksum_top dfrc_checker u_dfrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.value     (value),
	.status    (status)
);

`default_nettype wire

// ----- tb/frame_checker.sv -----
`timescale 1ns / 1ps

module frame_checker
	import dfrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       kind,
	input  logic [7:0] value,
	input  logic [2:0] status,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending_count
);

	typedef enum logic [2:0] {
		RX_IDLE,
		RX_ACK,
		RX_REASON,
		RX_HEADER,
		RX_DATA,
		RX_CHECK
	} rx_phase_e;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [2:0] status;
	} frame_result_t;

	// shadow of the register file and of the transfer state
	cfg_t          settings;
	rx_phase_e     rx_phase;
	logic [15:0]   byte_sum;
	logic [8:0]    data_count;
	logic [7:0]    digit_buf [4];
	logic [2:0]    digits_seen;
	logic [5:0]    quiet_ticks;
	frame_result_t expected_results [$];
	frame_result_t oldest;
	int            mismatches;

	// ascii checksum character to its nibble
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] t;
		t = c;
		if (t > CHAR_NINE) t = t - ALPHA_SHIFT;
		t = t - CHAR_ZERO;
		return t[3:0];
	endfunction

	task automatic clear_frame();
		byte_sum    = '0;
		data_count  = '0;
		digits_seen = '0;
		quiet_ticks = '0;
		for (int i = 0; i < 4; i++) digit_buf[i] = '0;
	endtask

	task automatic note_result(input logic k, input logic [7:0] v, input logic [2:0] s);
		frame_result_t r;
		r.kind   = k;
		r.value  = v;
		r.status = s;
		expected_results.push_back(r);
	endtask

	// advance the transfer by one accepted item
	task automatic predict_transfer(input logic [1:0] m, input logic [7:0] b);
		logic [15:0] check_word;
		logic        fwd;
		case (m)
			MODE_START: begin
				clear_frame();
				rx_phase = RX_ACK;
			end
			MODE_TICK: begin
				if (rx_phase != RX_IDLE) begin
					if (quiet_ticks < IDLE_MAX) quiet_ticks = quiet_ticks + 1'b1;
					if (quiet_ticks >= settings.timeout_seconds) begin
						rx_phase = RX_IDLE;
						note_result(KIND_STATUS, 8'd0, STATUS_TIMEOUT);
					end
				end
			end
			MODE_BYTE: begin
				if (rx_phase != RX_IDLE) begin
					quiet_ticks = '0;
					case (rx_phase)
						RX_ACK: begin
							if (b == settings.error_end_code && settings.level_two) begin
								rx_phase = RX_REASON;
							end else if (b != settings.normal_end_code) begin
								rx_phase = RX_IDLE;
								note_result(KIND_STATUS, 8'd0, STATUS_ACK_ERR);
							end else begin
								rx_phase = settings.level_two ? RX_HEADER : RX_DATA;
							end
						end
						RX_REASON: begin
							rx_phase = RX_IDLE;
							note_result(KIND_STATUS, b, STATUS_DEVICE);
						end
						RX_HEADER: begin
							if (b == LINE_FEED) rx_phase = RX_DATA;
						end
						RX_DATA: begin
							fwd = data_count >= {1'b0, settings.header_length};
							byte_sum = byte_sum + {8'd0, b};
							if (data_count != POS_MAX) data_count = data_count + 1'b1;
							if (b == settings.end_block_char) rx_phase = RX_CHECK;
							if (fwd) note_result(KIND_DATA, b, STATUS_OK);
						end
						RX_CHECK: begin
							if (b == settings.end_block_char) begin
								rx_phase = RX_IDLE;
								if (digits_seen < 3'd4) begin
									note_result(KIND_STATUS, 8'd0, STATUS_MISMATCH);
								end else begin
									// high byte digits come second on the wire
									check_word = {nibble_of(digit_buf[2]), nibble_of(digit_buf[3]),
										nibble_of(digit_buf[0]), nibble_of(digit_buf[1])};
									note_result(KIND_STATUS, 8'd0,
										(check_word == byte_sum) ? STATUS_OK : STATUS_MISMATCH);
								end
							end else if (digits_seen < 3'd4) begin
								digit_buf[digits_seen[1:0]] = b;
								digits_seen = digits_seen + 1'b1;
							end
						end
						default: rx_phase = RX_IDLE;
					endcase
				end
			end
			default: ;
		endcase
	endtask

	// compare results, follow register writes, predict from input transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.level_two       = 1'b1;
			settings.end_block_char  = 8'd26;
			settings.header_length   = 8'd0;
			settings.timeout_seconds = 6'd30;
			settings.normal_end_code = 8'd6;
			settings.error_end_code  = 8'd21;
			rx_phase = RX_IDLE;
			clear_frame();
			expected_results.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d value %0d status %0d", kind, value, status);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					if (kind !== oldest.kind) begin
						$error("kind: expected %0d, got %0d", oldest.kind, kind);
						mismatches++;
					end
					if (value !== oldest.value) begin
						$error("value: expected %0d, got %0d", oldest.value, value);
						mismatches++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEVEL_TWO:  settings.level_two       = cfg_data[0];
					REG_END_BLOCK:  settings.end_block_char  = cfg_data;
					REG_HEADER_LEN: settings.header_length   = cfg_data;
					REG_TIMEOUT:    settings.timeout_seconds = cfg_data[5:0];
					REG_NORMAL_END: settings.normal_end_code = cfg_data;
					REG_ERROR_END:  settings.error_end_code  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_transfer(mode, rx_byte);
			fail_count <= mismatches;
			pending_count <= expected_results.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import dfrc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] mode = MODE_START;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       kind;
	logic [7:0] value;
	logic [2:0] status;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = REG_LEVEL_TWO;
	logic [7:0] cfg_data = 8'd0;
	int         fail_count;
	int         pending_count;
	int         cycle_count = 0;
	int         items_sent = 0;
	bit         src_steady = 1'b0;
	bit         snk_steady = 1'b0;
	cfg_t       cur;

	data_frame_receiver_checksum_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	frame_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always #6 clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random back-pressure once a result shows up
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = snk_steady ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				out_ready <= 1'b0;
				@(posedge clk);
				while (!out_valid) @(posedge clk);
				repeat (stall - 1) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// one item transfer with a random gap in front
	task automatic send_item(input logic [1:0] m, input logic [7:0] b);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 16);
		if (m != MODE_UNUSED) items_sent++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t c);
		write_reg(REG_LEVEL_TWO, {7'd0, c.level_two});
		write_reg(REG_END_BLOCK, c.end_block_char);
		write_reg(REG_HEADER_LEN, c.header_length);
		write_reg(REG_TIMEOUT, {2'd0, c.timeout_seconds});
		write_reg(REG_NORMAL_END, c.normal_end_code);
		write_reg(REG_ERROR_END, c.error_end_code);
		cfg_valid <= 1'b0;
		cur = c;
	endtask

	// stop sending, let every expected result drain, then a short pause
	task automatic wait_quiet(input int pause);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) return 8'h30 + {4'd0, d};
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
	endfunction

	// check digits in wire order: low byte then high byte, high nibble first
	task automatic send_checksum(input logic [15:0] sum, input int count);
		logic [3:0] nib [4];
		nib[0] = sum[7:4];
		nib[1] = sum[3:0];
		nib[2] = sum[15:12];
		nib[3] = sum[11:8];
		for (int i = 0; i < count; i++)
			send_item(MODE_BYTE, hex_char(i < 4 ? nib[i] : 4'($urandom_range(0, 15))));
	endtask

	task automatic send_timeout_ticks();
		int n;
		n = (cur.timeout_seconds == 0) ? 1 : cur.timeout_seconds;
		repeat (n) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
	endtask

	// one transfer, mostly well formed, sometimes broken on purpose
	task automatic run_frame(input int long_len);
		int          n;
		int          twist;
		logic [15:0] total;
		logic [7:0]  b;
		send_item(MODE_START, 8'($urandom_range(0, 255)));
		case ($urandom_range(0, 19))
			0: begin
				send_item(MODE_BYTE, cur.error_end_code);
				send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
				return;
			end
			1: begin
				send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
				return;
			end
			default: send_item(MODE_BYTE, cur.normal_end_code);
		endcase
		if (cur.level_two) begin
			repeat ($urandom_range(0, 3)) begin
				b = 8'($urandom_range(0, 255));
				if (b == LINE_FEED) b = b ^ 8'h01;
				send_item(MODE_BYTE, b);
			end
			send_item(MODE_BYTE, LINE_FEED);
		end
		if (long_len != 0)
			n = long_len;
		else if (cur.header_length > 8'd12 && $urandom_range(0, 3) == 0)
			n = int'(cur.header_length) + $urandom_range(0, 4);
		else
			n = $urandom_range(0, 12);
		total = '0;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == cur.end_block_char) b = b ^ 8'h01;
			total = total + {8'd0, b};
			send_item(MODE_BYTE, b);
			if ($urandom_range(0, 15) == 0) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
		end
		twist = $urandom_range(0, 15);
		// restart while busy, or let the link go silent
		if (twist == 0) return;
		if (twist == 1) begin
			send_timeout_ticks();
			return;
		end
		send_item(MODE_BYTE, cur.end_block_char);
		total = total + {8'd0, cur.end_block_char};
		if (twist == 2) total = total ^ (16'd1 << $urandom_range(0, 15));
		case (twist)
			3: send_checksum(total, $urandom_range(0, 3));
			4: send_checksum(total, $urandom_range(5, 7));
			default: send_checksum(total, 4);
		endcase
		send_item(MODE_BYTE, cur.end_block_char);
	endtask

	// extremes first, then random register settings
	task automatic pick_settings(input int k, output cfg_t c);
		case (k)
			0: c = '{1'b0, 8'd0, 8'd0, 6'd1, 8'd0, 8'd255};
			1: c = '{1'b1, 8'd255, 8'd255, 6'd63, 8'd255, 8'd0};
			2: c = '{1'b1, 8'd26, 8'd2, 6'd0, 8'd6, 8'd6};
			default: begin
				c.level_two = 1'($urandom_range(0, 1));
				c.end_block_char = ($urandom_range(0, 3) == 0) ?
					8'($urandom_range(0, 255)) : 8'd26;
				c.header_length = ($urandom_range(0, 4) == 0) ?
					8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
				c.timeout_seconds = 6'($urandom_range(0, 63));
				c.normal_end_code = 8'($urandom_range(0, 255));
				c.error_end_code = ($urandom_range(0, 2) == 0) ?
					c.normal_end_code : 8'($urandom_range(0, 255));
			end
		endcase
	endtask

	initial begin : stimulus
		cfg_t next_cfg;
		int   k;
		int   phase_end;
		cur = '{1'b1, 8'd26, 8'd0, 6'd30, 8'd6, 8'd21};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray items while idle, including the unused mode
		send_item(MODE_BYTE, 8'hFF);
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_UNUSED, 8'h00);
		// error-end code followed by the device reason
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'd21);
		send_item(MODE_BYTE, 8'hA5);
		// unknown acknowledge
		send_item(MODE_START, 8'hFF);
		send_item(MODE_BYTE, 8'h00);
		// good transfer: header line, data FF 00 and end-of-block, sum 0x0119
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'd6);
		send_item(MODE_BYTE, 8'h78);
		send_item(MODE_BYTE, LINE_FEED);
		send_item(MODE_BYTE, 8'hFF);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'd26);
		send_checksum(16'h0119, 4);
		send_item(MODE_BYTE, 8'd26);
		// short checksum
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'd6);
		send_item(MODE_BYTE, LINE_FEED);
		send_item(MODE_BYTE, 8'd26);
		send_item(MODE_BYTE, 8'h31);
		send_item(MODE_BYTE, 8'd26);

		// random phases, each under its own register settings
		k = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_quiet(SETTLE_CYCLES);
			pick_settings(k, next_cfg);
			apply_settings(next_cfg);
			src_steady = ($urandom_range(0, 2) == 0);
			snk_steady = ($urandom_range(0, 2) == 0);
			// byte counter saturation, with forwarding past a long header
			if (k == 1) run_frame(520);
			phase_end = items_sent + $urandom_range(80, 180);
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				else
					run_frame(0);
			end
			k++;
		end

		wait_quiet(20);
		if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
